@@ rtl/paraboloid_time_slice_frame_store_top_defines.svh @@
// Assertion macros for the paraboloid time-slice frame store.
// Used by the port checker; needs clock and reset in the including scope.
`ifndef PARABOLOID_TIME_SLICE_FRAME_STORE_TOP_DEFINES_SVH
`define PARABOLOID_TIME_SLICE_FRAME_STORE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PTSFS_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptsfs port check failed");

// next-cycle implication, disabled in reset
`define PTSFS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptsfs port check failed");

`endif

@@ rtl/ptsfs_pkg.sv @@
// Shared types and constants of the paraboloid time-slice frame store.
// No dependencies.
package ptsfs_pkg;

   localparam int COORD_W     = 7;
   localparam int PIX_W       = 32;
   localparam int SIZE_W      = 8;
   localparam int GAIN_W      = 24;
   localparam int Z_W         = 17;
   localparam int DIVD_W      = COORD_W + 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int DATA_W      = 48;

   localparam logic [Z_W-1:0] ONE_Q16 = 17'h10000;

   typedef enum logic [0:0] {
      OP_STORE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      VIEW_FRONT  = 3'd0,
      VIEW_BACK   = 3'd1,
      VIEW_TOP    = 3'd2,
      VIEW_BOTTOM = 3'd3,
      VIEW_LEFT   = 3'd4,
      VIEW_RIGHT  = 3'd5
   } view_type;

   typedef enum logic [2:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_VIEW_DIR     = 3'd2,
      CSR_MIRROR_X     = 3'd3,
      CSR_GAIN_X       = 3'd4,
      CSR_GAIN_Y       = 3'd5,
      CSR_GAIN_Z       = 3'd6,
      CSR_OFFSET_Z     = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DIVX,
      BK_DIVY,
      BK_DIVT,
      BK_SQ,
      BK_GAIN,
      BK_SUM,
      BK_SCALE,
      BK_ZCLAMP,
      BK_MAP,
      BK_FSEL,
      BK_ADDR,
      BK_OUT
   } back_state_type;

   // effective configuration; width/height already clamped
   typedef struct packed {
      logic [SIZE_W-1:0]        width;
      logic [SIZE_W-1:0]        height;
      logic [2:0]               view_dir;
      logic                     mirror;
      logic signed [GAIN_W-1:0] gain_x;
      logic signed [GAIN_W-1:0] gain_y;
      logic signed [GAIN_W-1:0] gain_z;
      logic signed [GAIN_W-1:0] offset_z;
   } cfg_type;

   typedef struct packed {
      op_type             op;
      logic               store_en;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [PIX_W-1:0]   pixel;
      logic               frame_end;
   } item_type;

endpackage

@@ rtl/ptsfs_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on ptsfs_pkg.
module ptsfs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ptsfs_pkg::DIVD_W-1:0]  dividend,
   input  logic [ptsfs_pkg::SIZE_W-1:0]  divisor,
   output logic                          done,
   output logic [ptsfs_pkg::DIVD_W-1:0]  quotient
);
   localparam int CNT_W = $clog2(ptsfs_pkg::DIVD_W + 1);

   logic                          run_ff, done_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [ptsfs_pkg::SIZE_W-1:0]  rem_ff, divisor_ff;
   logic [ptsfs_pkg::DIVD_W-1:0]  quo_ff;
   logic [ptsfs_pkg::SIZE_W:0]    trial;
   logic                          ge;
   logic [ptsfs_pkg::SIZE_W-1:0]  rem_in;
   logic [ptsfs_pkg::DIVD_W-1:0]  quo_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[ptsfs_pkg::DIVD_W-1]};
      ge     = trial >= {1'b0, divisor_ff};
      rem_in = ge ? ptsfs_pkg::SIZE_W'(trial - {1'b0, divisor_ff})
                  : ptsfs_pkg::SIZE_W'(trial);
      quo_in = {quo_ff[ptsfs_pkg::DIVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff   <= 1'b1;
            count_ff <= CNT_W'(ptsfs_pkg::DIVD_W);
         end else if (run_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quo_ff     <= dividend;
         divisor_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ rtl/ptsfs_front.sv @@
// Front end: accepts request transactions, classifies them, queues them.
// Depends on ptsfs_pkg.
module ptsfs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  ptsfs_pkg::cfg_type            cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ptsfs_pkg::DATA_W-1:0]  req_tdata,
   input  logic                          req_tuser,
   input  logic                          req_tlast,
   input  logic                          q_pop,
   output logic                          q_valid,
   output ptsfs_pkg::item_type           q_item
);
   localparam int PTR_W = $clog2(ptsfs_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ptsfs_pkg::QUEUE_DEPTH + 1);

   ptsfs_pkg::item_type  queue_ff [ptsfs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   ptsfs_pkg::item_type  item_in;
   logic                 push;

   always_comb begin
      item_in.op        = ptsfs_pkg::op_type'(req_tuser);
      item_in.col       = req_tdata[6:0];
      item_in.row       = req_tdata[13:7];
      item_in.pixel     = req_tdata[45:14];
      item_in.frame_end = req_tlast;
      // stores outside the active frame only move the ring
      item_in.store_en  = ({1'b0, item_in.col} < cfg.width) &&
                          ({1'b0, item_in.row} < cfg.height);
   end

   assign req_tready = count_ff < CNT_W'(ptsfs_pkg::QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = count_ff != '0;
   assign q_item     = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (q_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !q_pop) count_ff <= count_ff + 1'b1;
         else if (!push && q_pop) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= item_in;
   end
endmodule

@@ rtl/ptsfs_back.sv @@
// Back end: frame ring memory, paraboloid time computation, result register.
// Depends on ptsfs_pkg and ptsfs_div.
module ptsfs_back #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int FRAMES     = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptsfs_pkg::cfg_type            cfg,
   input  logic                          q_valid,
   input  ptsfs_pkg::item_type           q_item,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ptsfs_pkg::COORD_W-1:0] rsp_col,
   output logic [ptsfs_pkg::COORD_W-1:0] rsp_row,
   output logic [ptsfs_pkg::PIX_W-1:0]   rsp_pixel
);
   localparam int SW    = $clog2(FRAMES);
   localparam int DEPTH = FRAMES * MAX_HEIGHT * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = ptsfs_pkg::COORD_W;
   localparam int ZW    = ptsfs_pkg::Z_W;
   localparam int DW    = ptsfs_pkg::DIVD_W;
   localparam int SZ    = ptsfs_pkg::SIZE_W;

   function automatic logic [AW-1:0] mem_addr(input logic [SW-1:0] s,
                                              input logic [SZ-1:0] y,
                                              input logic [SZ-1:0] x);
      mem_addr = AW'(s) * AW'(MAX_HEIGHT * MAX_WIDTH) + AW'(y) * AW'(MAX_WIDTH) + AW'(x);
   endfunction

   ptsfs_pkg::back_state_type state_ff, state_in;

   // control
   logic            div_start, div_done, mem_we, slot_adv, rsp_load;
   logic [DW-1:0]   div_dividend, div_quotient;
   logic [SZ-1:0]   div_divisor;

   // item and datapath registers
   logic [CW-1:0]              col_ff, row_ff;
   logic [DW-1:0]              xn_ff, yn_ff;
   logic [ZW-1:0]              qt_ff, qt_in;
   logic [27:0]                dx2_ff, dy2_ff, dx2_in, dy2_in;
   logic signed [52:0]         px_ff, py_ff, px_in, py_in;
   logic signed [36:0]         p_ff, p_in;
   logic signed [60:0]         pz_ff, pz_in;
   logic [ZW-1:0]              z_ff, z_in, zt_ff, zt_in;
   logic [SZ-1:0]              sx_ff, sy_ff, sx_in, sy_in;
   logic [SZ-1:0]              sxf_ff, syf_ff, sxf_in, syf_in;
   logic [SW-1:0]              f_ff, f_in, write_slot_ff;
   logic [ptsfs_pkg::PIX_W-1:0] rd_data_ff;
   logic                       rsp_valid_ff;
   logic [CW-1:0]              rsp_col_ff, rsp_row_ff;
   logic [ptsfs_pkg::PIX_W-1:0] rsp_pixel_ff;

   // helpers
   logic [SZ-1:0]      w_m1, h_m1;
   logic               is_vert, is_horz, flip;
   logic signed [23:0] dx, dy;
   logic signed [47:0] dxsq, dysq;
   logic signed [53:0] psum;
   logic signed [45:0] zs;
   logic [ZW-1:0]      zi;
   logic [SZ-1:0]      span, sxc, syc;
   logic [24:0]        cs_sum;
   logic [23:0]        f_sum;
   logic [7:0]         f_raw;
   logic [SW:0]        slot_sum, slot;
   logic [AW-1:0]      waddr, raddr;

   logic [ptsfs_pkg::PIX_W-1:0] mem [DEPTH];

   ptsfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign w_m1    = cfg.width - 1'b1;
   assign h_m1    = cfg.height - 1'b1;
   assign is_vert = cfg.view_dir == ptsfs_pkg::VIEW_TOP  || cfg.view_dir == ptsfs_pkg::VIEW_BOTTOM;
   assign is_horz = cfg.view_dir == ptsfs_pkg::VIEW_LEFT || cfg.view_dir == ptsfs_pkg::VIEW_RIGHT;
   assign flip    = cfg.view_dir == ptsfs_pkg::VIEW_BOTTOM ||
                    cfg.view_dir == ptsfs_pkg::VIEW_RIGHT;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      mem_we       = 1'b0;
      slot_adv     = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ptsfs_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.op == ptsfs_pkg::OP_STORE) begin
                  mem_we   = q_item.store_en;
                  slot_adv = q_item.frame_end;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = {q_item.col, 16'h0000};
                  div_divisor  = cfg.width;
                  state_in     = ptsfs_pkg::BK_DIVX;
               end
            end
         end
         ptsfs_pkg::BK_DIVX: begin
            if (div_done) begin
               div_start    = 1'b1;
               div_dividend = {row_ff, 16'h0000};
               div_divisor  = cfg.height;
               state_in     = ptsfs_pkg::BK_DIVY;
            end
         end
         ptsfs_pkg::BK_DIVY: begin
            if (div_done) begin
               if (is_vert || is_horz) begin
                  div_start    = 1'b1;
                  div_dividend = is_vert ? {row_ff, 16'h0000} : {col_ff, 16'h0000};
                  div_divisor  = is_vert ? h_m1 : w_m1;
                  state_in     = ptsfs_pkg::BK_DIVT;
               end else begin
                  state_in = ptsfs_pkg::BK_SQ;
               end
            end
         end
         ptsfs_pkg::BK_DIVT:   if (div_done) state_in = ptsfs_pkg::BK_SQ;
         ptsfs_pkg::BK_SQ:     state_in = ptsfs_pkg::BK_GAIN;
         ptsfs_pkg::BK_GAIN:   state_in = ptsfs_pkg::BK_SUM;
         ptsfs_pkg::BK_SUM:    state_in = ptsfs_pkg::BK_SCALE;
         ptsfs_pkg::BK_SCALE:  state_in = ptsfs_pkg::BK_ZCLAMP;
         ptsfs_pkg::BK_ZCLAMP: state_in = ptsfs_pkg::BK_MAP;
         ptsfs_pkg::BK_MAP:    state_in = ptsfs_pkg::BK_FSEL;
         ptsfs_pkg::BK_FSEL:   state_in = ptsfs_pkg::BK_ADDR;
         ptsfs_pkg::BK_ADDR:   state_in = ptsfs_pkg::BK_OUT;
         ptsfs_pkg::BK_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ptsfs_pkg::BK_IDLE;
            end
         end
         default: state_in = ptsfs_pkg::BK_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      qt_in  = (div_quotient > DW'(ptsfs_pkg::ONE_Q16)) ? ptsfs_pkg::ONE_Q16
                                                          : div_quotient[ZW-1:0];
      dx     = $signed({1'b0, xn_ff}) - 24'sd32768;
      dy     = $signed({1'b0, yn_ff}) - 24'sd32768;
      dxsq   = dx * dx;
      dysq   = dy * dy;
      dx2_in = dxsq[43:16];
      dy2_in = dysq[43:16];
      px_in  = $signed({1'b0, dx2_ff}) * cfg.gain_x;
      py_in  = $signed({1'b0, dy2_ff}) * cfg.gain_y;
      psum   = px_ff + py_ff;
      p_in   = $signed(psum[52:16]);
      pz_in  = p_ff * cfg.gain_z;
      zs     = $signed(pz_ff[60:16]) + cfg.offset_z;
      if (zs < 0) z_in = '0;
      else if (zs > 46'sd65536) z_in = ptsfs_pkg::ONE_Q16;
      else z_in = zs[ZW-1:0];

      // view mapping: ceil(z * span) picks the swapped coordinate
      zi     = flip ? ptsfs_pkg::ONE_Q16 - z_ff : z_ff;
      span   = is_vert ? h_m1 : w_m1;
      cs_sum = 25'(zi) * 25'(span) + 25'h0FFFF;
      sx_in  = SZ'(col_ff);
      sy_in  = SZ'(row_ff);
      if (is_vert) sy_in = cs_sum[23:16];
      if (is_horz) sx_in = cs_sum[23:16];
      unique case (cfg.view_dir)
         ptsfs_pkg::VIEW_FRONT:  zt_in = ptsfs_pkg::ONE_Q16 - z_ff;
         ptsfs_pkg::VIEW_TOP,
         ptsfs_pkg::VIEW_LEFT:   zt_in = qt_ff;
         ptsfs_pkg::VIEW_BOTTOM,
         ptsfs_pkg::VIEW_RIGHT:  zt_in = ptsfs_pkg::ONE_Q16 - qt_ff;
         default:                zt_in = z_ff;
      endcase

      sxc    = (sx_ff > w_m1) ? w_m1 : sx_ff;
      syc    = (sy_ff > h_m1) ? h_m1 : sy_ff;
      sxf_in = cfg.mirror ? w_m1 - sxc : sxc;
      syf_in = syc;
      f_sum  = 24'(zt_ff) * 24'(FRAMES - 1) + 24'h00FFFF;
      f_raw  = f_sum[23:16];
      f_in   = (f_raw > 8'(FRAMES - 1)) ? SW'(FRAMES - 1) : SW'(f_raw);

      slot_sum = {1'b0, write_slot_ff} + {1'b0, f_ff};
      slot     = (slot_sum >= (SW+1)'(FRAMES)) ? slot_sum - (SW+1)'(FRAMES) : slot_sum;
      raddr    = mem_addr(SW'(slot), syf_ff, sxf_ff);
      waddr    = mem_addr(write_slot_ff, SZ'(q_item.row), SZ'(q_item.col));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptsfs_pkg::BK_IDLE;
         write_slot_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (slot_adv)
            write_slot_ff <= (write_slot_ff == SW'(FRAMES - 1)) ? '0 : write_slot_ff + 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ptsfs_pkg::BK_IDLE && q_pop) begin
         col_ff <= q_item.col;
         row_ff <= q_item.row;
      end
      if (state_ff == ptsfs_pkg::BK_DIVX && div_done) xn_ff <= div_quotient;
      if (state_ff == ptsfs_pkg::BK_DIVY && div_done) yn_ff <= div_quotient;
      if (state_ff == ptsfs_pkg::BK_DIVT && div_done) qt_ff <= qt_in;
      if (state_ff == ptsfs_pkg::BK_SQ) begin
         dx2_ff <= dx2_in;
         dy2_ff <= dy2_in;
      end
      if (state_ff == ptsfs_pkg::BK_GAIN) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (state_ff == ptsfs_pkg::BK_SUM)    p_ff  <= p_in;
      if (state_ff == ptsfs_pkg::BK_SCALE)  pz_ff <= pz_in;
      if (state_ff == ptsfs_pkg::BK_ZCLAMP) z_ff  <= z_in;
      if (state_ff == ptsfs_pkg::BK_MAP) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         zt_ff <= zt_in;
      end
      if (state_ff == ptsfs_pkg::BK_FSEL) begin
         sxf_ff <= sxf_in;
         syf_ff <= syf_in;
         f_ff   <= f_in;
      end
      if (rsp_load) begin
         rsp_col_ff   <= col_ff;
         rsp_row_ff   <= row_ff;
         rsp_pixel_ff <= rd_data_ff;
      end
   end

   // frame ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= q_item.pixel;
      if (state_ff == ptsfs_pkg::BK_ADDR) rd_data_ff <= mem[raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_pixel  = rsp_pixel_ff;
endmodule

@@ rtl/paraboloid_time_slice_frame_store_top.sv @@
// Top level of the paraboloid time-slice frame store.
// Depends on ptsfs_pkg, ptsfs_front, ptsfs_back (and ptsfs_div below it).

// Slit-scan frame store: a ring of FRAMES frames of up to MAX_WIDTH x MAX_HEIGHT
// RGBA pixels. A store transaction (tuser = 0) writes one pixel into the slot being
// loaded; tlast on a store advances the ring. A read transaction (tuser = 1)
// returns the pixel at (col,row) taken from a frame chosen per pixel by a centred
// paraboloid time value, with the view direction and mirror applied; results come
// out in order, one per read. Output is meaningful once FRAMES frames are loaded.
// Flow: requests go into a two-entry queue, so the port keeps accepting while
// the back end works, until the queue is full. In the back end a store writes
// memory as it leaves the queue. A read uses the shared one-bit-per-cycle
// divider for two coordinate normalizations (front and back views) or three
// (top, bottom, left and right), then seven multiply/clamp/select stages, one
// registered memory read and the output load.
// A finished result sits in the output register while the next item proceeds.
// The user writes config registers through csr_* only while the block is idle (not enforced).
module paraboloid_time_slice_frame_store_top #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int FRAMES     = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // col[6:0], row[13:7], pixel_in[45:14], zero fill
   input  logic         req_tuser,   // opcode: 0 store, 1 read
   input  logic         req_tlast,   // frame_end
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // out_col[6:0], out_row[13:7], pixel_out[45:14], zero fill
   // register write port
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [23:0]  csr_wdata
);
   logic [7:0]  frame_width_ff, frame_height_ff;
   logic [2:0]  view_dir_ff;
   logic        mirror_ff;
   logic [23:0] gain_x_ff, gain_y_ff, gain_z_ff, offset_z_ff;

   ptsfs_pkg::cfg_type  cfg;
   ptsfs_pkg::item_type q_item;
   logic                q_valid, q_pop;
   logic [6:0]          rsp_col, rsp_row;
   logic [31:0]         rsp_pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 8'd128;
         frame_height_ff <= 8'd128;
         view_dir_ff     <= 3'(ptsfs_pkg::VIEW_FRONT);
         mirror_ff       <= 1'b0;
         gain_x_ff       <= 24'h010000;
         gain_y_ff       <= 24'h010000;
         gain_z_ff       <= 24'h010000;
         offset_z_ff     <= 24'h000000;
      end else if (csr_we) begin
         unique case (ptsfs_pkg::csr_index_type'(csr_addr))
            ptsfs_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[7:0];
            ptsfs_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[7:0];
            ptsfs_pkg::CSR_VIEW_DIR:     view_dir_ff     <= csr_wdata[2:0];
            ptsfs_pkg::CSR_MIRROR_X:     mirror_ff       <= csr_wdata[0];
            ptsfs_pkg::CSR_GAIN_X:       gain_x_ff       <= csr_wdata;
            ptsfs_pkg::CSR_GAIN_Y:       gain_y_ff       <= csr_wdata;
            ptsfs_pkg::CSR_GAIN_Z:       gain_z_ff       <= csr_wdata;
            ptsfs_pkg::CSR_OFFSET_Z:     offset_z_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective sizes: at least 2, at most the built frame size
   always_comb begin
      if (frame_width_ff < 8'd2) cfg.width = 8'd2;
      else if (32'(frame_width_ff) > MAX_WIDTH) cfg.width = 8'(MAX_WIDTH);
      else cfg.width = frame_width_ff;
      if (frame_height_ff < 8'd2) cfg.height = 8'd2;
      else if (32'(frame_height_ff) > MAX_HEIGHT) cfg.height = 8'(MAX_HEIGHT);
      else cfg.height = frame_height_ff;
      cfg.view_dir = view_dir_ff;
      cfg.mirror   = mirror_ff;
      cfg.gain_x   = $signed(gain_x_ff);
      cfg.gain_y   = $signed(gain_y_ff);
      cfg.gain_z   = $signed(gain_z_ff);
      cfg.offset_z = $signed(offset_z_ff);
   end

   ptsfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_pop      (q_pop),
      .q_valid    (q_valid),
      .q_item     (q_item)
   );

   ptsfs_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAMES     (FRAMES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_col    (rsp_col),
      .rsp_row    (rsp_row),
      .rsp_pixel  (rsp_pixel)
   );

   assign rsp_tdata = {2'b00, rsp_pixel, rsp_row, rsp_col};
endmodule

@@ rtl/ptsfs_checker.sv @@
// Port-level checker for the frame store, bound to the top level.
// Depends on paraboloid_time_slice_frame_store_top_defines.svh.
`include "paraboloid_time_slice_frame_store_top_defines.svh"

module ptsfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   // stalled response holds
   `PTSFS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // no stale result survives reset
   `PTSFS_ASSERT_IMPLY(a_rsp_clear, $past(reset), !rsp_tvalid)
   // queue comes out of reset empty
   `PTSFS_ASSERT_IMPLY(a_req_open, $past(reset), req_tready)
endmodule

bind paraboloid_time_slice_frame_store_top ptsfs_checker u_ptsfs_checker (.*);
